// ===== src/vzp_pkg.sv =====
package vzp_pkg;

    // Field widths
    localparam int COORD_W   = 24;
    localparam int ZOOM_W    = 16;
    localparam int SIZE_W    = 24;
    localparam int INSET_W   = 2 * SIZE_W;
    localparam int FRAC_W    = 8;
    localparam int REQ_W     = 2;

    // Serial multiplier / divider widths
    localparam int MCAND_W   = (COORD_W + 1 > SIZE_W) ? COORD_W + 1 : SIZE_W;
    localparam int PROD_W    = MCAND_W + ZOOM_W;
    localparam int SCALED_W  = PROD_W - FRAC_W;
    localparam int WIDE_W    = PROD_W + 2;
    localparam int MUL_CNT_W = $clog2(ZOOM_W + 1);
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);

    // Register port
    localparam int APB_DW    = 64;
    localparam int REG_IDX_W = 3;
    localparam int REG_LSB   = 3;
    localparam int PADDR_W   = REG_IDX_W + REG_LSB;

    // Zoom constants, Q8.8
    localparam logic [ZOOM_W-1:0] ZOOM_ONE     = ZOOM_W'(1 << FRAC_W);
    localparam logic [ZOOM_W-1:0] ZOOM_MAX_RST = ZOOM_W'(4 << FRAC_W);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [ZOOM_W-1:0]         t_zoom;
    typedef logic [SIZE_W-1:0]         t_size;
    typedef logic [INSET_W-1:0]        t_inset;
    typedef logic [MCAND_W-1:0]        t_mcand;
    typedef logic [PROD_W-1:0]         t_prod;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    typedef enum logic [REQ_W-1:0] {
        REQ_PAN        = 2'd0,
        REQ_PINCH      = 2'd1,
        REQ_SET_ZOOM   = 2'd2,
        REQ_SET_OFFSET = 2'd3
    } t_req;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BOUNDS_W   = 3'd0,
        REG_BOUNDS_H   = 3'd1,
        REG_CONTENT_W  = 3'd2,
        REG_CONTENT_H  = 3'd3,
        REG_INSET_H    = 3'd4,
        REG_INSET_V    = 3'd5,
        REG_ZOOM_MIN   = 3'd6,
        REG_ZOOM_MAX   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        t_size  bounds_width;
        t_size  bounds_height;
        t_size  content_width;
        t_size  content_height;
        t_inset inset_horiz;
        t_inset inset_vert;
        t_zoom  zoom_min;
        t_zoom  zoom_max;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ZM_GO,
        S_ZM_WAIT,
        S_ZCLAMP,
        S_PSUB,
        S_PM_GO,
        S_PM_WAIT,
        S_PD_GO,
        S_PD_WAIT,
        S_PFIX,
        S_SM_GO,
        S_SM_WAIT,
        S_CA,
        S_CB,
        S_CC,
        S_CD,
        S_OUT
    } t_state;

endpackage

// ===== src/vzp_regs.sv =====
module vzp_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vzp_pkg::PADDR_W-1:0] paddr,
    input  logic [vzp_pkg::APB_DW-1:0]  pwdata,
    output logic [vzp_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output vzp_pkg::t_cfg               o_cfg
);
    import vzp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[PADDR_W-1:REG_LSB]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write on the access phase of a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bounds_width   <= '0;
            r_cfg.bounds_height  <= '0;
            r_cfg.content_width  <= '0;
            r_cfg.content_height <= '0;
            r_cfg.inset_horiz    <= '0;
            r_cfg.inset_vert     <= '0;
            r_cfg.zoom_min       <= ZOOM_ONE;
            r_cfg.zoom_max       <= ZOOM_MAX_RST;
        end else if (wr) begin
            unique case (idx)
                REG_BOUNDS_W:  r_cfg.bounds_width   <= pwdata[SIZE_W-1:0];
                REG_BOUNDS_H:  r_cfg.bounds_height  <= pwdata[SIZE_W-1:0];
                REG_CONTENT_W: r_cfg.content_width  <= pwdata[SIZE_W-1:0];
                REG_CONTENT_H: r_cfg.content_height <= pwdata[SIZE_W-1:0];
                REG_INSET_H:   r_cfg.inset_horiz    <= pwdata[INSET_W-1:0];
                REG_INSET_V:   r_cfg.inset_vert     <= pwdata[INSET_W-1:0];
                REG_ZOOM_MIN:  r_cfg.zoom_min       <= pwdata[ZOOM_W-1:0];
                REG_ZOOM_MAX:  r_cfg.zoom_max       <= pwdata[ZOOM_W-1:0];
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_BOUNDS_W:  prdata = APB_DW'(r_cfg.bounds_width);
            REG_BOUNDS_H:  prdata = APB_DW'(r_cfg.bounds_height);
            REG_CONTENT_W: prdata = APB_DW'(r_cfg.content_width);
            REG_CONTENT_H: prdata = APB_DW'(r_cfg.content_height);
            REG_INSET_H:   prdata = APB_DW'(r_cfg.inset_horiz);
            REG_INSET_V:   prdata = APB_DW'(r_cfg.inset_vert);
            REG_ZOOM_MIN:  prdata = APB_DW'(r_cfg.zoom_min);
            REG_ZOOM_MAX:  prdata = APB_DW'(r_cfg.zoom_max);
        endcase
    end

endmodule

// ===== src/vzp_mul.sv =====
module vzp_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  vzp_pkg::t_mcand      i_mcand,
    input  vzp_pkg::t_zoom       i_mplier,
    output logic                 o_done,
    output vzp_pkg::t_prod       o_prod
);
    import vzp_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    t_mcand               r_a;
    t_prod                r_acc;
    logic [MCAND_W:0]     sum;

    // Add the multiplicand when the low multiplier bit is set
    assign sum = {1'b0, r_acc[PROD_W-1:ZOOM_W]} + (r_acc[0] ? {1'b0, r_a} : '0);

    assign o_done = r_done;
    assign o_prod = r_acc;

    // Control: one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == MUL_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(ZOOM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - MUL_CNT_W'(1);
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Shift the accumulator right as partial products enter at the top
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_mcand;
            r_acc <= {{MCAND_W{1'b0}}, i_mplier};
        end else if (r_busy) begin
            r_acc <= {sum, r_acc[ZOOM_W-1:1]};
        end
    end

endmodule

// ===== src/vzp_div.sv =====
module vzp_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  vzp_pkg::t_prod       i_dividend,
    input  vzp_pkg::t_zoom       i_divisor,
    output logic                 o_done,
    output vzp_pkg::t_prod       o_quot
);
    import vzp_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    t_zoom                r_d;
    t_zoom                r_rem;
    t_prod                r_q;
    logic [ZOOM_W:0]      shifted;
    logic [ZOOM_W:0]      diff;
    logic                 ge;

    // Restoring step: bring down the next dividend bit and try a subtract
    assign shifted = {r_rem, r_q[PROD_W-1]};
    assign diff    = shifted - {1'b0, r_d};
    assign ge      = shifted >= {1'b0, r_d};

    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(PROD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Quotient bits shift in where dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d   <= i_divisor;
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[ZOOM_W-1:0] : shifted[ZOOM_W-1:0];
            r_q   <= {r_q[PROD_W-2:0], ge};
        end
    end

endmodule

// ===== src/viewport_zoom_pan_clamp.sv =====
// Viewport zoom/pan controller. One request is taken at a time: o_stall is
// high from the cycle after a transfer until its result has been placed in
// the output register, which holds while i_stall is high. A pan, set-zoom or
// set-offset result shows as the input reopens; per axis it takes one pass
// of the 16-step serial multiplier (scaled content size) and four clamp
// states, then the output register is loaded. A pinch first runs a
// multiplier pass and clamp for the new zoom, then per axis a subtract
// state, one multiplier pass, one pass of the 41-step restoring divider
// and a fix-up state. While an earlier result is still stalled, the next
// one waits to be loaded. Registers sit at byte address 8*index on the
// APB port; writes take effect at once and should be made while no request
// is open.
module viewport_zoom_pan_clamp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vzp_pkg::PADDR_W-1:0] paddr,
    input  logic [vzp_pkg::APB_DW-1:0]  pwdata,
    output logic [vzp_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,

    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [vzp_pkg::REQ_W-1:0]   i_req_type,
    input  vzp_pkg::t_coord             i_delta_x,
    input  vzp_pkg::t_coord             i_delta_y,
    input  vzp_pkg::t_coord             i_center_x,
    input  vzp_pkg::t_coord             i_center_y,
    input  vzp_pkg::t_zoom              i_scale_factor,
    input  vzp_pkg::t_zoom              i_zoom_value,
    input  vzp_pkg::t_coord             i_new_offset_x,
    input  vzp_pkg::t_coord             i_new_offset_y,

    output logic                        o_valid,
    input  logic                        i_stall,
    output vzp_pkg::t_coord             o_view_offset_x,
    output vzp_pkg::t_coord             o_view_offset_y,
    output vzp_pkg::t_zoom              o_view_zoom
);
    import vzp_pkg::*;

    typedef logic signed [MCAND_W-1:0] t_sdiff;

    localparam t_wide SAT_HI = {{(WIDE_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam t_wide SAT_LO = {{(WIDE_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    function automatic t_wide sext_c(input t_coord v);
        return {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic t_wide zext_s(input t_size v);
        return {{(WIDE_W-SIZE_W){1'b0}}, v};
    endfunction

    // Limit to [max(zmin,1), zmax], the lower bound winning
    function automatic t_zoom clamp_zoom(input logic [SCALED_W-1:0] z,
                                         input t_zoom zmin, input t_zoom zmax);
        logic [SCALED_W-1:0] lo;
        logic [SCALED_W-1:0] hi;
        logic [SCALED_W-1:0] zc;
        lo = (zmin == '0) ? SCALED_W'(1) : SCALED_W'(zmin);
        hi = SCALED_W'(zmax);
        zc = (z > hi) ? hi : z;
        zc = (zc < lo) ? lo : zc;
        return zc[ZOOM_W-1:0];
    endfunction

    t_cfg   cfg;
    t_state r_state, n_state;
    logic   r_axis;
    t_zoom  r_zoom, r_znew;
    t_coord r_ox, r_oy;
    t_coord r_cx, r_cy;
    t_zoom  r_scale;
    t_wide  r_wx, r_wy;
    t_sdiff r_diff;
    t_wide  r_t1, r_iab, r_lo, r_hi, r_cl;
    logic   r_o_valid;
    t_coord r_out_x, r_out_y;
    t_zoom  r_out_z;

    logic   mul_start, mul_done, div_start, div_done;
    t_mcand mul_a;
    t_zoom  mul_b;
    t_prod  mul_prod, div_quot;
    logic   accept, out_load;
    t_req   req;

    t_size  b_sel, cont_sel, ia_sel, ib_sel;
    t_inset ins_sel;
    t_coord c_sel, o_sel;
    t_wide  w_sel, s_w, q_w, c_w, rnd, half, sat_val;
    t_mcand diff_mag;
    logic   narrow;

    vzp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vzp_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mul_a),
        .i_mplier (mul_b),
        .o_done   (mul_done),
        .o_prod   (mul_prod)
    );

    vzp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_prod),
        .i_divisor  (r_zoom),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign req    = t_req'(i_req_type);
    assign accept = i_valid && !o_stall;

    // Per-axis operand selection
    assign b_sel    = r_axis ? cfg.bounds_height : cfg.bounds_width;
    assign cont_sel = r_axis ? cfg.content_height : cfg.content_width;
    assign ins_sel  = r_axis ? cfg.inset_vert : cfg.inset_horiz;
    assign ia_sel   = ins_sel[INSET_W-1:SIZE_W];
    assign ib_sel   = ins_sel[SIZE_W-1:0];
    assign c_sel    = r_axis ? r_cy : r_cx;
    assign o_sel    = r_axis ? r_oy : r_ox;
    assign w_sel    = r_axis ? r_wy : r_wx;

    // Arithmetic views
    assign s_w      = {{(WIDE_W-SCALED_W){1'b0}}, mul_prod[PROD_W-1:FRAC_W]};
    assign q_w      = {{(WIDE_W-PROD_W){1'b0}}, div_quot};
    assign c_w      = sext_c(c_sel);
    assign diff_mag = r_diff[MCAND_W-1] ? t_mcand'(-r_diff) : t_mcand'(r_diff);
    assign narrow   = r_t1 > r_iab;
    assign rnd      = {{(WIDE_W-1){1'b0}}, r_t1[WIDE_W-1] & r_t1[0]};
    assign half     = (r_t1 >>> 1) + rnd;
    assign sat_val  = (r_cl > SAT_HI) ? SAT_HI : ((r_cl < SAT_LO) ? SAT_LO : r_cl);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_valid) n_state = (req == REQ_PINCH) ? S_ZM_GO : S_SM_GO;
            S_ZM_GO:   n_state = S_ZM_WAIT;
            S_ZM_WAIT: if (mul_done) n_state = S_ZCLAMP;
            S_ZCLAMP:  n_state = S_PSUB;
            S_PSUB:    n_state = S_PM_GO;
            S_PM_GO:   n_state = S_PM_WAIT;
            S_PM_WAIT: if (mul_done) n_state = S_PD_GO;
            S_PD_GO:   n_state = S_PD_WAIT;
            S_PD_WAIT: if (div_done) n_state = S_PFIX;
            S_PFIX:    n_state = r_axis ? S_SM_GO : S_PSUB;
            S_SM_GO:   n_state = S_SM_WAIT;
            S_SM_WAIT: if (mul_done) n_state = S_CA;
            S_CA:      n_state = S_CB;
            S_CB:      n_state = S_CC;
            S_CC:      n_state = S_CD;
            S_CD:      n_state = r_axis ? S_OUT : S_SM_GO;
            S_OUT:     if (!r_o_valid || !i_stall) n_state = S_IDLE;
        endcase
    end

    // State outputs: unit launches and handshake
    always_comb begin
        o_stall   = 1'b1;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: o_stall = 1'b0;
            S_ZM_GO: begin
                mul_start = 1'b1;
                mul_a     = {{(MCAND_W-ZOOM_W){1'b0}}, r_zoom};
                mul_b     = r_scale;
            end
            S_PM_GO: begin
                mul_start = 1'b1;
                mul_a     = diff_mag;
                mul_b     = r_znew;
            end
            S_SM_GO: begin
                mul_start = 1'b1;
                mul_a     = {{(MCAND_W-SIZE_W){1'b0}}, cont_sel};
                mul_b     = r_znew;
            end
            S_PD_GO: div_start = 1'b1;
            S_OUT:   out_load  = !r_o_valid || !i_stall;
            default: ;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_axis    <= 1'b0;
            r_zoom    <= ZOOM_ONE;
            r_ox      <= '0;
            r_oy      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_axis <= 1'b0;
            end else if (r_state == S_PFIX || r_state == S_CD) begin
                r_axis <= !r_axis;
            end
            if (r_state == S_CD) begin
                if (r_axis) begin
                    r_oy <= sat_val[COORD_W-1:0];
                end else begin
                    r_ox <= sat_val[COORD_W-1:0];
                end
            end
            if (out_load) begin
                r_zoom    <= r_znew;
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_scale <= i_scale_factor;
            unique case (req)
                REQ_PAN: begin
                    r_znew <= r_zoom;
                    r_wx   <= sext_c(r_ox) + sext_c(i_delta_x);
                    r_wy   <= sext_c(r_oy) + sext_c(i_delta_y);
                end
                REQ_SET_ZOOM: begin
                    r_znew <= clamp_zoom({{(SCALED_W-ZOOM_W){1'b0}}, i_zoom_value},
                                         cfg.zoom_min, cfg.zoom_max);
                    r_wx   <= sext_c(r_ox);
                    r_wy   <= sext_c(r_oy);
                end
                REQ_SET_OFFSET: begin
                    r_znew <= r_zoom;
                    r_wx   <= sext_c(i_new_offset_x);
                    r_wy   <= sext_c(i_new_offset_y);
                end
                REQ_PINCH: begin
                    r_znew <= r_zoom;
                    r_wx   <= sext_c(r_ox);
                    r_wy   <= sext_c(r_oy);
                end
            endcase
        end

        unique case (r_state)
            S_ZCLAMP: r_znew <= clamp_zoom(mul_prod[PROD_W-1:FRAC_W],
                                           cfg.zoom_min, cfg.zoom_max);
            S_PSUB: begin
                r_diff <= {{(MCAND_W-COORD_W){c_sel[COORD_W-1]}}, c_sel}
                        - {{(MCAND_W-COORD_W){o_sel[COORD_W-1]}}, o_sel};
            end
            S_PFIX: begin
                // undo the sign taken off before the divide
                if (r_axis) begin
                    r_wy <= r_diff[MCAND_W-1] ? c_w + q_w : c_w - q_w;
                end else begin
                    r_wx <= r_diff[MCAND_W-1] ? c_w + q_w : c_w - q_w;
                end
            end
            S_CA: begin
                r_t1  <= zext_s(b_sel) - s_w;
                r_iab <= zext_s(ia_sel) + zext_s(ib_sel);
            end
            S_CB: begin
                // narrow content centers, otherwise limit to the scroll range
                r_lo <= narrow ? half : r_t1 - zext_s(ib_sel);
                r_hi <= narrow ? half : zext_s(ia_sel);
            end
            S_CC: begin
                r_cl <= (w_sel < r_lo) ? r_lo : ((w_sel > r_hi) ? r_hi : w_sel);
            end
            default: ;
        endcase

        if (out_load) begin
            r_out_x <= r_ox;
            r_out_y <= r_oy;
            r_out_z <= r_znew;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_view_offset_x = r_out_x;
    assign o_view_offset_y = r_out_y;
    assign o_view_zoom     = r_out_z;

endmodule

// ===== src/vzp_checker.sv =====
module vzp_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input vzp_pkg::t_coord o_view_offset_x,
    input vzp_pkg::t_coord o_view_offset_y,
    input vzp_pkg::t_zoom  o_view_zoom
);
    import vzp_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_view_offset_x)
            && $stable(o_view_offset_y) && $stable(o_view_zoom))
        else $error("result changed while stalled");

    // One request at a time: a transfer closes the input side
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input open right after a transfer");

    // A new result appears exactly as the block reopens its input
    a_result_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $fell(o_stall))
        else $error("result appeared without the block going idle");

    // Zoom is never zero
    a_zoom_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_view_zoom != '0)
        else $error("zero zoom on output");

endmodule

bind viewport_zoom_pan_clamp vzp_checker u_vzp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_view_offset_x (o_view_offset_x),
    .o_view_offset_y (o_view_offset_y),
    .o_view_zoom     (o_view_zoom)
);

// ===== verif/viewport_zoom_pan_clamp_test.sv =====
module viewport_zoom_pan_clamp_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vzp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int          ITEM_TARGET = 1300;
    localparam t_coord      COORD_HI    = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord      COORD_LO    = {1'b1, {(COORD_W-1){1'b0}}};

    // One gesture request as it crosses the input port
    typedef struct packed {
        t_req   kind;
        t_coord dx, dy, cx, cy;
        t_zoom  scale, zval;
        t_coord nx, ny;
    } t_gesture;

    // One viewport result as it crosses the output port
    typedef struct packed {
        t_coord ox;
        t_coord oy;
        t_zoom  zoom;
    } t_view;

    // Track zoom and offset, predict every viewport result and check it
    class view_scoreboard;
        t_cfg        cfg;
        t_zoom       cur_zoom;
        longint      cur_x;
        longint      cur_y;
        t_view       pending_views[$];
        int unsigned errors;

        function new();
            cfg = '0;
            cfg.zoom_min = ZOOM_ONE;
            cfg.zoom_max = ZOOM_MAX_RST;
            cur_zoom = ZOOM_ONE;
            cur_x = 0;
            cur_y = 0;
            errors = 0;
        endfunction

        // Store a register write, return what a readback should show
        function logic [APB_DW-1:0] set_reg(t_reg_idx idx, logic [APB_DW-1:0] v);
            case (idx)
                REG_BOUNDS_W: begin
                    cfg.bounds_width = t_size'(v);
                    return APB_DW'(cfg.bounds_width);
                end
                REG_BOUNDS_H: begin
                    cfg.bounds_height = t_size'(v);
                    return APB_DW'(cfg.bounds_height);
                end
                REG_CONTENT_W: begin
                    cfg.content_width = t_size'(v);
                    return APB_DW'(cfg.content_width);
                end
                REG_CONTENT_H: begin
                    cfg.content_height = t_size'(v);
                    return APB_DW'(cfg.content_height);
                end
                REG_INSET_H: begin
                    cfg.inset_horiz = t_inset'(v);
                    return APB_DW'(cfg.inset_horiz);
                end
                REG_INSET_V: begin
                    cfg.inset_vert = t_inset'(v);
                    return APB_DW'(cfg.inset_vert);
                end
                REG_ZOOM_MIN: begin
                    cfg.zoom_min = t_zoom'(v);
                    return APB_DW'(cfg.zoom_min);
                end
                default: begin
                    cfg.zoom_max = t_zoom'(v);
                    return APB_DW'(cfg.zoom_max);
                end
            endcase
        endfunction

        // Limit zoom to the configured range; a zero minimum acts as one
        // and the minimum wins over a smaller maximum
        function longint fit_zoom(longint z);
            longint lo = longint'(cfg.zoom_min);
            longint hi = longint'(cfg.zoom_max);
            if (lo < 1) lo = 1;
            if (z > hi) z = hi;
            if (z < lo) z = lo;
            return z;
        endfunction

        // Center narrow content, else hold the offset inside the scroll range
        function longint settle_axis(longint off, t_size bounds, t_size content,
                                     t_inset inset);
            longint b  = longint'(bounds);
            longint ia = longint'(inset[INSET_W-1:SIZE_W]);
            longint ib = longint'(inset[SIZE_W-1:0]);
            longint s  = (longint'(content) * longint'(cur_zoom)) >>> FRAC_W;
            longint e  = b - ia - ib;
            longint lim = (longint'(1) <<< (COORD_W - 1)) - 1;
            longint lo;
            longint hi;
            if (s < e) begin
                lo = (b - s) / 2;
                hi = lo;
            end else begin
                lo = b - ib - s;
                hi = ia;
            end
            if (off < lo) off = lo;
            else if (off > hi) off = hi;
            // Saturate to the coordinate range
            if (off > lim) off = lim;
            else if (off < -lim - 1) off = -lim - 1;
            return off;
        endfunction

        // Advance the viewport for one accepted gesture and queue its result
        function void note_request(t_gesture g);
            longint zold;
            longint znew;
            longint px;
            longint py;
            t_view  v;
            zold = longint'(cur_zoom);
            px = cur_x;
            py = cur_y;
            case (g.kind)
                REQ_PAN: begin
                    px = cur_x + longint'(g.dx);
                    py = cur_y + longint'(g.dy);
                end
                REQ_PINCH: begin
                    // Keep the content point under the center fixed
                    znew = fit_zoom((zold * longint'(g.scale)) >>> FRAC_W);
                    px = longint'(g.cx) - ((longint'(g.cx) - cur_x) * znew) / zold;
                    py = longint'(g.cy) - ((longint'(g.cy) - cur_y) * znew) / zold;
                    cur_zoom = t_zoom'(znew);
                end
                REQ_SET_ZOOM: begin
                    cur_zoom = t_zoom'(fit_zoom(longint'(g.zval)));
                end
                default: begin
                    px = longint'(g.nx);
                    py = longint'(g.ny);
                end
            endcase
            cur_x = settle_axis(px, cfg.bounds_width, cfg.content_width, cfg.inset_horiz);
            cur_y = settle_axis(py, cfg.bounds_height, cfg.content_height, cfg.inset_vert);
            v.ox = t_coord'(cur_x);
            v.oy = t_coord'(cur_y);
            v.zoom = cur_zoom;
            pending_views.push_back(v);
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_view(t_coord ox, t_coord oy, t_zoom zoom);
            t_view w;
            if (pending_views.size() == 0) begin
                $error("result transfer with no request pending");
                errors++;
                return;
            end
            w = pending_views.pop_front();
            if (w.ox !== ox) begin
                $error("view_offset_x: expected %0d, actual %0d", w.ox, ox);
                errors++;
            end
            if (w.oy !== oy) begin
                $error("view_offset_y: expected %0d, actual %0d", w.oy, oy);
                errors++;
            end
            if (w.zoom !== zoom) begin
                $error("view_zoom: expected %0d, actual %0d", w.zoom, zoom);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                i_valid;
    logic                o_stall;
    logic [REQ_W-1:0]    i_req_type;
    t_coord              i_delta_x;
    t_coord              i_delta_y;
    t_coord              i_center_x;
    t_coord              i_center_y;
    t_zoom               i_scale_factor;
    t_zoom               i_zoom_value;
    t_coord              i_new_offset_x;
    t_coord              i_new_offset_y;
    logic                o_valid;
    logic                i_stall;
    t_coord              o_view_offset_x;
    t_coord              o_view_offset_y;
    t_zoom               o_view_zoom;

    view_scoreboard sb = new();
    bit             calm;
    int             sent;
    int unsigned    cycle_count;

    viewport_zoom_pan_clamp dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_delta_x       (i_delta_x),
        .i_delta_y       (i_delta_y),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_scale_factor  (i_scale_factor),
        .i_zoom_value    (i_zoom_value),
        .i_new_offset_x  (i_new_offset_x),
        .i_new_offset_y  (i_new_offset_y),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_view_offset_x (o_view_offset_x),
        .o_view_offset_y (o_view_offset_y),
        .o_view_zoom     (o_view_zoom)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // End the run if it hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Stall the result side at random, except in the calm stretch
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= !calm && ($urandom_range(99) < 18);
        end
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_view(o_view_offset_x, o_view_offset_y, o_view_zoom);
    end

    function automatic t_coord pix(int n);
        return t_coord'(n <<< FRAC_W);
    endfunction

    function automatic t_coord rand_coord();
        if ($urandom_range(1) == 0)
            return t_coord'($urandom);
        return t_coord'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    function automatic t_size rand_size();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return t_size'($urandom);
            default: return t_size'($urandom_range(64, 4096) << FRAC_W);
        endcase
    endfunction

    function automatic t_size rand_inset();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return t_size'($urandom);
            default: return t_size'($urandom_range(0, 64 << FRAC_W));
        endcase
    endfunction

    function automatic t_gesture rand_gesture();
        t_gesture g;
        g.kind  = t_req'($urandom_range(3));
        g.dx    = rand_coord();
        g.dy    = rand_coord();
        g.cx    = rand_coord();
        g.cy    = rand_coord();
        g.nx    = rand_coord();
        g.ny    = rand_coord();
        g.scale = ($urandom_range(2) == 0) ? t_zoom'($urandom) : t_zoom'($urandom_range(128, 512));
        g.zval  = ($urandom_range(2) == 0) ? t_zoom'($urandom) : t_zoom'($urandom_range(32, 2048));
        return g;
    endfunction

    // Write one register, then read it back
    task automatic write_reg(t_reg_idx idx, logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] kept;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << REG_LSB;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        kept = sb.set_reg(idx, value);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== kept) begin
            $error("register %s readback: expected %0h, actual %0h", idx.name(), kept, prdata);
            sb.errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(t_size bw, t_size bh, t_size cw, t_size ch,
                              t_inset ih, t_inset iv, t_zoom zmin, t_zoom zmax);
        write_reg(REG_BOUNDS_W,  APB_DW'(bw));
        write_reg(REG_BOUNDS_H,  APB_DW'(bh));
        write_reg(REG_CONTENT_W, APB_DW'(cw));
        write_reg(REG_CONTENT_H, APB_DW'(ch));
        write_reg(REG_INSET_H,   APB_DW'(ih));
        write_reg(REG_INSET_V,   APB_DW'(iv));
        write_reg(REG_ZOOM_MIN,  APB_DW'(zmin));
        write_reg(REG_ZOOM_MAX,  APB_DW'(zmax));
    endtask

    // Pick a random setting with extremes mixed in
    task automatic new_setting();
        t_zoom zmin;
        t_zoom zmax;
        case ($urandom_range(7))
            0:       zmin = '0;
            1:       zmin = 16'd1;
            2:       zmin = '1;
            3:       zmin = t_zoom'($urandom);
            default: zmin = t_zoom'($urandom_range(32, 256));
        endcase
        case ($urandom_range(7))
            0:       zmax = '1;
            1:       zmax = 16'd1;
            2:       zmax = t_zoom'($urandom);
            default: zmax = t_zoom'($urandom_range(256, 4096));
        endcase
        set_config(rand_size(), rand_size(), rand_size(), rand_size(),
                   {rand_inset(), rand_inset()}, {rand_inset(), rand_inset()}, zmin, zmax);
    endtask

    // Present one gesture and hold it until the block takes it
    task automatic send_request(t_gesture g);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < 18)
            gap = $urandom_range(1, 8);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_req_type     <= g.kind;
        i_delta_x      <= g.dx;
        i_delta_y      <= g.dy;
        i_center_x     <= g.cx;
        i_center_y     <= g.cy;
        i_scale_factor <= g.scale;
        i_zoom_value   <= g.zval;
        i_new_offset_x <= g.nx;
        i_new_offset_y <= g.ny;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(g);
        sent++;
    endtask

    // Send one operation with the fields it uses given, the rest random
    task automatic send_op(t_req kind, t_coord x, t_coord y, t_zoom s);
        t_gesture g;
        g = rand_gesture();
        g.kind = kind;
        case (kind)
            REQ_PAN: begin
                g.dx = x;
                g.dy = y;
            end
            REQ_PINCH: begin
                g.cx = x;
                g.cy = y;
                g.scale = s;
            end
            REQ_SET_ZOOM: begin
                g.zval = s;
            end
            default: begin
                g.nx = x;
                g.ny = y;
            end
        endcase
        send_request(g);
    endtask

    // Drop valid and hold off until every predicted result has arrived
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_views.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int phase;
        int count;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_valid        = 1'b0;
        i_req_type     = REQ_PAN;
        i_delta_x      = '0;
        i_delta_y      = '0;
        i_center_x     = '0;
        i_center_y     = '0;
        i_scale_factor = '0;
        i_zoom_value   = '0;
        i_new_offset_x = '0;
        i_new_offset_y = '0;
        calm           = 1'b0;
        sent           = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Scrollable content with uneven insets
        set_config(t_size'(800 << FRAC_W), t_size'(600 << FRAC_W),
                   t_size'(2000 << FRAC_W), t_size'(1500 << FRAC_W),
                   {t_size'(10 << FRAC_W), t_size'(20 << FRAC_W)},
                   {t_size'(5 << FRAC_W), t_size'(15 << FRAC_W)},
                   16'd128, 16'd2048);
        send_op(REQ_PAN, pix(1000), pix(-500), '0);
        send_op(REQ_PAN, COORD_HI, COORD_HI, '0);
        send_op(REQ_PAN, COORD_LO, COORD_LO, '0);
        send_op(REQ_SET_ZOOM, '0, '0, '0);
        send_op(REQ_SET_ZOOM, '0, '0, '1);
        send_op(REQ_SET_ZOOM, '0, '0, ZOOM_ONE);
        send_op(REQ_PINCH, pix(400), pix(300), 16'd512);
        send_op(REQ_PINCH, COORD_HI, COORD_LO, '1);
        send_op(REQ_PINCH, pix(100), pix(50), '0);
        send_op(REQ_PINCH, COORD_LO, COORD_LO, ZOOM_ONE);
        send_op(REQ_SET_OFFSET, COORD_HI, COORD_HI, '0);
        send_op(REQ_SET_OFFSET, COORD_LO, COORD_LO, '0);
        send_op(REQ_SET_OFFSET, pix(-100), pix(-50), '0);
        send_op(REQ_SET_ZOOM, '0, '0, 16'd64);
        drain_results();

        // Full-scale sizes, insets wider than the view, zero minimum zoom
        set_config('1, '1, '1, '1, '1, '1, '0, '1);
        send_op(REQ_SET_ZOOM, '0, '0, '0);
        send_op(REQ_PAN, '0, '0, '0);
        send_op(REQ_PINCH, COORD_HI, COORD_HI, '1);
        send_op(REQ_SET_ZOOM, '0, '0, '1);
        send_op(REQ_PINCH, COORD_LO, COORD_HI, '1);
        send_op(REQ_SET_OFFSET, COORD_LO, COORD_LO, '0);
        send_op(REQ_PAN, COORD_HI, COORD_HI, '0);
        send_op(REQ_PAN, COORD_HI, COORD_HI, '0);
        drain_results();

        // Narrow content gets centered; misordered zoom limits
        set_config(t_size'(800 << FRAC_W), t_size'(600 << FRAC_W),
                   t_size'(100 << FRAC_W), t_size'(100 << FRAC_W), '0, '0,
                   16'd1024, 16'd256);
        send_op(REQ_SET_ZOOM, '0, '0, 16'd512);
        send_op(REQ_PINCH, pix(10), pix(20), ZOOM_ONE);
        send_op(REQ_SET_OFFSET, '0, '0, '0);
        drain_results();

        // Random phases, each under its own setting
        phase = 0;
        while (sent < ITEM_TARGET) begin
            new_setting();
            calm = (phase == 2);
            count = calm ? 250 : $urandom_range(60, 200);
            repeat (count) begin
                send_request(rand_gesture());
                if ($urandom_range(49) == 0)
                    drain_results();
            end
            drain_results();
            phase++;
        end
        calm = 1'b0;

        // Let any stray result show up
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_views.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (sb.pending_views.size() != 0)
                $error("%0d predicted results never arrived", sb.pending_views.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
